// ===== design/hvn_pkg.sv =====
// Package for the heightmap vertex and normal generator.
// Holds the result record, register indexes and reset values, sequencer states, row-slot helpers and the normal clamp.
// No dependencies.
package hvn_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GRID_WIDTH   = 2'd0,
        CFG_GRID_DEPTH   = 2'd1,
        CFG_UNIT_SCALE   = 2'd2,
        CFG_HEIGHT_SCALE = 2'd3
    } hvn_cfg_idx_t;

    // Register reset values.
    localparam logic [10:0] GRID_DIM_RESET     = 11'd1;
    localparam logic [23:0] UNIT_SCALE_RESET   = 24'd6554;
    localparam logic [23:0] HEIGHT_SCALE_RESET = 24'd26;

    // Normal used when all three unnormalized normal components are zero.
    localparam logic signed [15:0] NORMAL_ONE = 16'sd32767;

    // Sequencer states of the vertex engine.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_NORM,
        ST_SQ,
        ST_ROOT,
        ST_DIV,
        ST_DONE
    } hvn_state_t;

    // One emitted vertex.
    typedef struct packed {
        logic               last_vertex;
        logic signed [15:0] normal_z;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_x;
        logic [31:0]        pos_z;
        logic [31:0]        pos_y;
        logic [31:0]        pos_x;
        logic [19:0]        vertex_index;
    } hvn_result_t;

    // Line-store slot of the previous row (rows rotate through three slots).
    function automatic logic [1:0] slot_prev(input logic [1:0] s);
        logic [1:0] r;
        case (s)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    // Line-store slot of the next row.
    function automatic logic [1:0] slot_next(input logic [1:0] s);
        logic [1:0] r;
        case (s)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Clamp a rounded quotient and apply the sign of the component.
    function automatic logic signed [15:0] norm_fix(input logic [15:0] q, input logic neg);
        logic [15:0] r;
        if (neg) begin
            r = (q > 16'd32768) ? 16'd32768 : q;
            r = 16'd0 - r;
        end else begin
            r = (q > 16'd32767) ? 16'd32767 : q;
        end
        return $signed(r);
    endfunction

endpackage

// ===== design/hvn_line_store.sv =====
// Three-row line store of height samples, one row per slot.
// One write port, one read port with registered data. Uses hvn_pkg.
module hvn_line_store import hvn_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [1:0]                   wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
    input  logic [7:0]                   wr_data,
    input  logic [1:0]                   rd_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
    output logic [7:0]                   rd_data
);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW1 = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] ROW2 = AW'(2 * MAX_WIDTH);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Slot base plus column.
    always_comb begin
        case (wr_slot)
            2'd0:    wr_addr = AW'(wr_col);
            2'd1:    wr_addr = ROW1 + AW'(wr_col);
            default: wr_addr = ROW2 + AW'(wr_col);
        endcase
        case (rd_slot)
            2'd0:    rd_addr = AW'(rd_col);
            2'd1:    rd_addr = ROW1 + AW'(rd_col);
            default: rd_addr = ROW2 + AW'(rd_col);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/hvn_mul.sv =====
// Shared 32 by 32 unsigned multiplier with a registered product.
// Used by the vertex engine for every product. Uses hvn_pkg.
module hvn_mul import hvn_pkg::*; (
    input  logic        aclk,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    output logic [63:0] mul_p
);
    always_ff @(posedge aclk) begin
        mul_p <= 64'(mul_a) * 64'(mul_b);
    end
endmodule

// ===== design/hvn_core.sv =====
// Vertex engine: reads the five neighbor samples, forms positions and the
// Q1.15 normal through one shared multiplier and one shared subtractor.
// Depends on hvn_pkg and hvn_mul.
module hvn_core import hvn_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [$clog2(MAX_WIDTH)-1:0]   x_in,
    input  logic [$clog2(MAX_DEPTH)-1:0]   z_in,
    input  logic [1:0]                     slot_in,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] w_in,
    input  logic [$clog2(MAX_DEPTH+1)-1:0] d_in,
    input  logic [23:0]                    unit_scale,
    input  logic [23:0]                    height_scale,
    output logic                           idle,
    output logic [1:0]                     rd_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]   rd_col,
    input  logic [7:0]                     rd_data,
    output logic                           res_valid,
    input  logic                           res_ack,
    output hvn_result_t                    result
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int ZW = $clog2(MAX_DEPTH);

    hvn_state_t  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  ci_reg, ci_next;
    logic [XW-1:0] x_reg, x_next;
    logic [ZW-1:0] z_reg, z_next;
    logic [1:0]  slot_reg, slot_next_v;
    logic [7:0]  h_reg [5];
    logic [7:0]  h_next [5];
    logic [33:0] ma_reg, ma_next, mb_reg, mb_next, mc_reg, mc_next;
    logic [31:0] t_reg, t_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] r_reg, r_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] nlo_reg, nlo_next;
    logic [15:0] q_reg, q_next;
    hvn_result_t res_reg, res_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [64:0] sub_a, sub_b, sub_d;
    logic        borrow;

    logic [XW-1:0]      xl, xr;
    logic [1:0]         slot_l, slot_r;
    logic               x_edge, z_edge;
    logic signed [10:0] sx, sy;
    logic [9:0]         sx_abs, sy_abs;
    logic [33:0]        m_max;
    logic [63:0]        root_bit;
    logic [32:0]        rem2;
    logic [46:0]        num;
    logic [30:0]        mag;
    logic               mag_neg;

    hvn_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    // Neighbor coordinates with clamping at the grid border.
    always_comb begin
        xl     = (x_reg != '0) ? x_reg - 1'b1 : x_reg;
        xr     = (32'(x_reg) + 1 < 32'(w_in)) ? x_reg + 1'b1 : x_reg;
        slot_l = (z_reg != '0) ? slot_prev(slot_reg) : slot_reg;
        slot_r = (32'(z_reg) + 1 < 32'(d_in)) ? slot_next(slot_reg) : slot_reg;
        x_edge = (x_reg == '0) || (32'(x_reg) + 1 == 32'(w_in));
        z_edge = (z_reg == '0) || (32'(z_reg) + 1 == 32'(d_in));
    end

    // Central differences, doubled at border vertices.
    always_comb begin
        sx = $signed({3'b000, h_reg[2]}) - $signed({3'b000, h_reg[1]});
        sy = $signed({3'b000, h_reg[4]}) - $signed({3'b000, h_reg[3]});
        if (x_edge) begin
            sx = sx <<< 1;
        end
        if (z_edge) begin
            sy = sy <<< 1;
        end
        sx_abs = sx[10] ? 10'(-sx) : 10'(sx);
        sy_abs = sy[10] ? 10'(-sy) : 10'(sy);
        m_max  = (ma_reg > mb_reg) ? ma_reg : mb_reg;
        if (mc_reg > m_max) begin
            m_max = mc_reg;
        end
    end

    // Shared subtractor operands for the square root and the divider.
    always_comb begin
        root_bit = 64'd1 << (6'd62 - {cnt_reg[4:0], 1'b0});
        rem2     = {rem_reg, nlo_reg[15]};
        case (ci_reg)
            2'd0:    begin mag = ma_reg[30:0]; mag_neg = (sx > 0); end
            2'd1:    begin mag = mb_reg[30:0]; mag_neg = 1'b0;     end
            default: begin mag = mc_reg[30:0]; mag_neg = (sy > 0); end
        endcase
        num = {1'b0, mag, 15'd0} + 47'(n_reg >> 1);
        if (state_reg == ST_ROOT) begin
            sub_a = {1'b0, acc_reg};
            sub_b = {1'b0, r_reg + root_bit};
        end else begin
            sub_a = 65'(rem2);
            sub_b = 65'(n_reg);
        end
        sub_d  = sub_a - sub_b;
        borrow = sub_d[64];
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL) begin
            case (cnt_reg)
                6'd0: begin mul_a = 32'(sx_abs);   mul_b = 32'(height_scale); end
                6'd1: begin mul_a = 32'(sy_abs);   mul_b = 32'(height_scale); end
                6'd2: begin mul_a = 32'(x_reg);    mul_b = 32'(unit_scale);   end
                6'd3: begin mul_a = 32'(z_reg);    mul_b = 32'(unit_scale);   end
                6'd4: begin mul_a = 32'(h_reg[0]); mul_b = 32'(height_scale); end
                6'd5: begin mul_a = 32'(z_reg);    mul_b = 32'(w_in);         end
                6'd6: begin mul_a = t_reg;         mul_b = 32'(unit_scale);   end
                default: begin mul_a = '0;         mul_b = '0;                end
            endcase
        end else if (state_reg == ST_SQ) begin
            case (cnt_reg)
                6'd0:    begin mul_a = ma_reg[31:0]; mul_b = ma_reg[31:0]; end
                6'd1:    begin mul_a = mb_reg[31:0]; mul_b = mb_reg[31:0]; end
                6'd2:    begin mul_a = mc_reg[31:0]; mul_b = mc_reg[31:0]; end
                default: begin mul_a = '0;           mul_b = '0;           end
            endcase
        end
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ci_next     = ci_reg;
        x_next      = x_reg;
        z_next      = z_reg;
        slot_next_v = slot_reg;
        h_next      = h_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        mc_next     = mc_reg;
        t_next      = t_reg;
        acc_next    = acc_reg;
        r_next      = r_reg;
        n_next      = n_reg;
        rem_next    = rem_reg;
        nlo_next    = nlo_reg;
        q_next      = q_reg;
        res_next    = res_reg;
        rd_slot     = slot_reg;
        rd_col      = x_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    x_next      = x_in;
                    z_next      = z_in;
                    slot_next_v = slot_in;
                    cnt_next    = '0;
                    state_next  = ST_LOAD;
                end
            end

            // Issue five reads; each sample returns in the cycle after its read.
            ST_LOAD: begin
                case (cnt_reg)
                    6'd1:    begin rd_slot = slot_reg; rd_col = xl;    end
                    6'd2:    begin rd_slot = slot_reg; rd_col = xr;    end
                    6'd3:    begin rd_slot = slot_l;   rd_col = x_reg; end
                    6'd4:    begin rd_slot = slot_r;   rd_col = x_reg; end
                    default: begin rd_slot = slot_reg; rd_col = x_reg; end
                endcase
                if (cnt_reg != '0) begin
                    h_next[3'(cnt_reg - 6'd1)] = rd_data;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd5) begin
                    cnt_next   = '0;
                    mb_next    = {9'd0, unit_scale, 1'b0};
                    state_next = ST_MUL;
                end
            end

            // Products, one issued per cycle, each captured in the cycle after its issue.
            ST_MUL: begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    6'd0: begin
                        res_next.last_vertex = (32'(x_reg) + 1 == 32'(w_in)) &&
                                               (32'(z_reg) + 1 == 32'(d_in));
                    end
                    6'd1: ma_next = mul_p[33:0];
                    6'd2: mc_next = mul_p[33:0];
                    6'd3: res_next.pos_x = (mul_p[63:32] != '0) ? '1 : mul_p[31:0];
                    6'd4: res_next.pos_z = (mul_p[63:32] != '0) ? '1 : mul_p[31:0];
                    6'd5: t_next = mul_p[31:0];
                    6'd6: res_next.vertex_index = mul_p[19:0] + 20'(x_reg);
                    6'd7: begin
                        res_next.pos_y = (mul_p[63:48] != '0) ? '1 : mul_p[47:16];
                        cnt_next = '0;
                        if (m_max == '0) begin
                            res_next.normal_x = '0;
                            res_next.normal_y = NORMAL_ONE;
                            res_next.normal_z = '0;
                            state_next        = ST_DONE;
                        end else begin
                            state_next = ST_NORM;
                        end
                    end
                    default: cnt_next = '0;
                endcase
            end

            // Bring the largest magnitude into [2^30, 2^31).
            ST_NORM: begin
                if (m_max[33:31] != '0) begin
                    ma_next = ma_reg >> 1;
                    mb_next = mb_reg >> 1;
                    mc_next = mc_reg >> 1;
                end else if (m_max[30:26] == '0) begin
                    ma_next = ma_reg << 4;
                    mb_next = mb_reg << 4;
                    mc_next = mc_reg << 4;
                end else if (!m_max[30]) begin
                    ma_next = ma_reg << 1;
                    mb_next = mb_reg << 1;
                    mc_next = mc_reg << 1;
                end else begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end

            // Sum of squares.
            ST_SQ: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0) begin
                    acc_next = '0;
                end else begin
                    acc_next = acc_reg + mul_p;
                end
                if (cnt_reg == 6'd3) begin
                    cnt_next   = '0;
                    r_next     = '0;
                    state_next = ST_ROOT;
                end
            end

            // Integer square root, one result bit per cycle.
            ST_ROOT: begin
                if (!borrow) begin
                    acc_next = sub_d[63:0];
                    r_next   = (r_reg >> 1) + root_bit;
                end else begin
                    r_next = r_reg >> 1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd31) begin
                    n_next     = r_next[31:0];
                    cnt_next   = '0;
                    ci_next    = '0;
                    state_next = ST_DIV;
                end
            end

            // Rounded division of each magnitude by the norm, one quotient bit per cycle.
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0) begin
                    rem_next = 32'(num[46:16]);
                    nlo_next = num[15:0];
                    q_next   = '0;
                end else begin
                    rem_next = borrow ? rem2[31:0] : sub_d[31:0];
                    nlo_next = {nlo_reg[14:0], 1'b0};
                    q_next   = {q_reg[14:0], !borrow};
                end
                if (cnt_reg == 6'd16) begin
                    case (ci_reg)
                        2'd0:    res_next.normal_x = norm_fix(q_next, mag_neg);
                        2'd1:    res_next.normal_y = norm_fix(q_next, mag_neg);
                        default: res_next.normal_z = norm_fix(q_next, mag_neg);
                    endcase
                    cnt_next = '0;
                    if (ci_reg == 2'd2) begin
                        state_next = ST_DONE;
                    end else begin
                        ci_next = ci_reg + 1'b1;
                    end
                end
            end

            ST_DONE: begin
                if (res_ack) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ci_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ci_reg    <= ci_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        z_reg    <= z_next;
        slot_reg <= slot_next_v;
        h_reg    <= h_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        mc_reg   <= mc_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
        r_reg    <= r_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        nlo_reg  <= nlo_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign result    = res_reg;

    // The largest magnitude is normalized before the squares are formed.
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ) |-> (m_max[33:30] == 4'b0001))
        else $error("magnitudes not normalized before squaring");

    // The root of a normalized sum is at least 2^30.
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (n_reg[31:30] != 2'b00))
        else $error("norm below 2^30 in division");

    // A result appears only after the product pass or the last division.
    a_done_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(res_valid) |-> ($past(state_reg) == ST_MUL || $past(state_reg) == ST_DIV))
        else $error("result raised from an unexpected state");

endmodule

// ===== design/heightmap_vertex_normal_gen.sv =====
// Top level of the heightmap vertex and normal generator: registers, raster
// counters, line store, vertex engine and output register.
// Depends on hvn_pkg, hvn_line_store and hvn_core.
//
//  Channel  Direction  Payload
//  s_       in         tuser: opcode; tdata: height
//  m_       out        tdata: vertex index, position, normal; tlast: last vertex
//  cfg_     in         write enable, register index, write data
//
// A sample or drain tick that yields no vertex leaves s_tready high. One that yields
// a vertex keeps s_tready low while the engine runs the line-store reads, the
// products on the shared multiplier, normalizing, the squares, the bit-serial
// square root, three 16-bit restoring divisions on the shared subtractor and the
// hand-over of the result to the output register. When all three normal
// magnitudes are zero, the engine skips from the products to the hand-over.
// Reset is synchronous and active low; the line store needs no clearing pass.
// A stalled result waits in the output register while the next item may already
// be accepted; a second finished vertex holds the engine until that register drains.
module heightmap_vertex_normal_gen import hvn_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_DEPTH = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] height
    input  logic [0:0]   s_tuser,   // [0] opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    // [19:0] vertex_index, [51:20] pos_x, [83:52] pos_y, [115:84] pos_z,
    // [131:116] normal_x, [147:132] normal_y, [163:148] normal_z, rest zero
    output logic [167:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_wdata
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int ZW = $clog2(MAX_DEPTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic [10:0]   grid_width_reg, grid_depth_reg;
    logic [23:0]   unit_scale_reg, height_scale_reg;
    logic [XW-1:0] in_col_reg, in_col_next;
    logic [DW-1:0] in_row_reg, in_row_next;
    logic [1:0]    in_slot_reg, in_slot_next;
    logic [WW-1:0] drain_col_reg, drain_col_next;
    logic          out_valid_reg, out_valid_next;
    hvn_result_t   out_reg;

    logic [WW-1:0] w_eff;
    logic [DW-1:0] d_eff;
    logic          accept, restart;
    logic [XW-1:0] c0;
    logic [DW-1:0] r0;
    logic [1:0]    s0;
    logic          wr_en;
    logic          start;
    logic [XW-1:0] start_x;
    logic [ZW-1:0] start_z;
    logic [1:0]    start_slot;
    logic          core_idle, res_valid, res_ack;
    hvn_result_t   result;
    logic [1:0]    rd_slot;
    logic [XW-1:0] rd_col;
    logic [7:0]    rd_data;

    // Effective grid size: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (grid_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(grid_width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(grid_width_reg);
        end
        if (grid_depth_reg == '0) begin
            d_eff = DW'(1);
        end else if (32'(grid_depth_reg) > MAX_DEPTH) begin
            d_eff = DW'(MAX_DEPTH);
        end else begin
            d_eff = DW'(grid_depth_reg);
        end
    end

    assign accept = s_tvalid && s_tready;
    assign restart = (32'(in_row_reg) >= 32'(d_eff));

    // Raster counters, line-store write and vertex launch.
    always_comb begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_slot_next   = in_slot_reg;
        drain_col_next = drain_col_reg;
        wr_en          = 1'b0;
        start          = 1'b0;
        start_x        = in_col_reg;
        start_z        = '0;
        start_slot     = slot_prev(in_slot_reg);
        c0 = restart ? '0 : in_col_reg;
        r0 = restart ? '0 : in_row_reg;
        s0 = restart ? 2'd0 : in_slot_reg;

        if (accept && !s_tuser[0]) begin
            // A sample is dropped while the final row is still draining.
            if (!(restart && (32'(drain_col_reg) < 32'(w_eff)))) begin
                wr_en = 1'b1;
                if (restart) begin
                    drain_col_next = '0;
                end
                if (r0 != '0) begin
                    start      = 1'b1;
                    start_x    = c0;
                    start_z    = ZW'(r0 - 1'b1);
                    start_slot = slot_prev(s0);
                end
                if (32'(c0) + 1 >= 32'(w_eff)) begin
                    in_col_next  = '0;
                    in_row_next  = r0 + 1'b1;
                    in_slot_next = slot_next(s0);
                end else begin
                    in_col_next  = c0 + 1'b1;
                    in_row_next  = r0;
                    in_slot_next = s0;
                end
            end
        end else if (accept && s_tuser[0]) begin
            // Drain tick: emit the next vertex of the final row.
            if (restart && (32'(drain_col_reg) < 32'(w_eff))) begin
                start          = 1'b1;
                start_x        = XW'(drain_col_reg);
                start_z        = ZW'(d_eff - 1'b1);
                start_slot     = slot_prev(in_slot_reg);
                drain_col_next = drain_col_reg + 1'b1;
            end
        end

        // A new grid size starts a new grid.
        if (cfg_wr_en && (hvn_cfg_idx_t'(cfg_index) == CFG_GRID_WIDTH ||
                          hvn_cfg_idx_t'(cfg_index) == CFG_GRID_DEPTH)) begin
            in_col_next    = '0;
            in_row_next    = '0;
            in_slot_next   = 2'd0;
            drain_col_next = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg   <= GRID_DIM_RESET;
            grid_depth_reg   <= GRID_DIM_RESET;
            unit_scale_reg   <= UNIT_SCALE_RESET;
            height_scale_reg <= HEIGHT_SCALE_RESET;
        end else if (cfg_wr_en) begin
            case (hvn_cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:   grid_width_reg   <= cfg_wdata[10:0];
                CFG_GRID_DEPTH:   grid_depth_reg   <= cfg_wdata[10:0];
                CFG_UNIT_SCALE:   unit_scale_reg   <= cfg_wdata;
                CFG_HEIGHT_SCALE: height_scale_reg <= cfg_wdata;
                default:          grid_width_reg   <= grid_width_reg;
            endcase
        end
    end

    // Counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= 2'd0;
            drain_col_reg <= '0;
        end else begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_slot_reg   <= in_slot_next;
            drain_col_reg <= drain_col_next;
        end
    end

    hvn_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_slot (s0),
        .wr_col  (c0),
        .wr_data (s_tdata),
        .rd_slot (rd_slot),
        .rd_col  (rd_col),
        .rd_data (rd_data)
    );

    hvn_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .x_in         (start_x),
        .z_in         (start_z),
        .slot_in      (start_slot),
        .w_in         (w_eff),
        .d_in         (d_eff),
        .unit_scale   (unit_scale_reg),
        .height_scale (height_scale_reg),
        .idle         (core_idle),
        .rd_slot      (rd_slot),
        .rd_col       (rd_col),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res_ack      (res_ack),
        .result       (result)
    );

    assign s_tready = core_idle;

    // Output register: loads a finished vertex when empty or being drained.
    assign res_ack = res_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_ack) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last_vertex;
    assign m_tdata  = {4'd0, out_reg.normal_z, out_reg.normal_y, out_reg.normal_x,
                       out_reg.pos_z, out_reg.pos_y, out_reg.pos_x, out_reg.vertex_index};

    // The input column always lies inside the current row.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(in_col_reg) < 32'(w_eff))
        else $error("input column outside the grid width");

    // Draining never runs past the row end.
    a_drain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(drain_col_reg) <= 32'(w_eff))
        else $error("drain column beyond the grid width");

    // Draining only starts once every row is in.
    a_drain_after_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_col_reg != '0) |-> (32'(in_row_reg) >= 32'(d_eff)))
        else $error("drain in progress before the grid is complete");

endmodule
